### hdl/hsvc_pkg.sv
// Shared types, widths and constants of the RGB to HSV pixel converter.
package hsvc_pkg;

    localparam int PIX_W     = 8;   // channel and result width
    localparam int DIV_STEPS = 8;   // quotient bits, one per divider stage
    localparam int NUM_W     = 21;  // dividend width: 17 * 360 * 255 < 2**21
    localparam int DVS_W     = 13;  // divisor width: 24 * 255 < 2**13
    localparam int SUM_W     = NUM_W + 1;

    // Hue dividend is 17*N with N = base*d + 60*diff; fold 17 into the constants.
    localparam logic [DVS_W-1:0] HUE_K_RED_POS = DVS_W'(0);     // 17 * 0
    localparam logic [DVS_W-1:0] HUE_K_RED_NEG = DVS_W'(6120);  // 17 * 360
    localparam logic [DVS_W-1:0] HUE_K_GREEN   = DVS_W'(2040);  // 17 * 120
    localparam logic [DVS_W-1:0] HUE_K_BLUE    = DVS_W'(4080);  // 17 * 240
    localparam logic signed [SUM_W-1:0] HUE_K_DIFF = SUM_W'(1020);  // 17 * 60

    typedef enum logic [1:0] {
        SEC_RED_POS,
        SEC_RED_NEG,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Items that ride along with the division
    typedef struct packed {
        logic             zero;        // black or grey pixel
        logic [PIX_W-1:0] brightness;
    } t_side;

    // One restoring-division lane between stages
    typedef struct packed {
        logic [DVS_W-1:0]     rem;
        logic [DIV_STEPS-1:0] low;
        logic [DIV_STEPS-1:0] quo;
        logic [DVS_W-1:0]     dvs;
    } t_lane;

    // Load a lane; the caller guarantees dividend < divisor * 2**DIV_STEPS
    function automatic t_lane lane_load(input logic [NUM_W-1:0] num,
                                        input logic [DVS_W-1:0] dvs);
        t_lane l;
        l.rem = num[NUM_W-1:DIV_STEPS];
        l.low = num[DIV_STEPS-1:0];
        l.quo = '0;
        l.dvs = dvs;
        return l;
    endfunction

    // Produce one quotient bit
    function automatic t_lane lane_step(input t_lane l);
        t_lane      n;
        logic [DVS_W:0] t;
        t = {l.rem, l.low[DIV_STEPS-1]};
        n = l;
        n.low = {l.low[DIV_STEPS-2:0], 1'b0};
        if (t >= {1'b0, l.dvs}) begin
            n.rem = DVS_W'(t - {1'b0, l.dvs});
            n.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            n.rem = t[DVS_W-1:0];
            n.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

### hdl/hsvc_front.sv
// Front stages: max/min and sector pick, then dividends and divisors.
module hsvc_front
    import hsvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [PIX_W-1:0]     i_red,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_blue,
    output logic                 o_vld,
    output logic [NUM_W-1:0]     o_hue_num,
    output logic [DVS_W-1:0]     o_hue_dvs,
    output logic [NUM_W-1:0]     o_sat_num,
    output logic [DVS_W-1:0]     o_sat_dvs,
    output t_side                o_side
);

    // stage A
    logic                    r_a_vld;
    logic [PIX_W-1:0]        r_a_max, n_a_max;
    logic [PIX_W-1:0]        r_a_d, n_a_d;
    t_sector                 r_a_sec, n_a_sec;
    logic signed [PIX_W:0]   r_a_diff, n_a_diff;

    // stage B
    logic                    r_b_vld;
    logic [NUM_W-1:0]        r_b_hue_num, n_b_hue_num;
    logic [DVS_W-1:0]        r_b_hue_dvs, n_b_hue_dvs;
    logic [NUM_W-1:0]        r_b_sat_num, n_b_sat_num;
    logic [DVS_W-1:0]        r_b_sat_dvs, n_b_sat_dvs;
    t_side                   r_b_side, n_b_side;

    logic [PIX_W-1:0]        l_min;
    logic [DVS_W-1:0]        l_k;
    logic [NUM_W-1:0]        l_base;
    logic signed [SUM_W-1:0] l_diff_ext;
    logic signed [SUM_W-1:0] l_sum;

    always_comb begin
        n_a_max = (i_red > i_green) ? i_red : i_green;
        n_a_max = (n_a_max > i_blue) ? n_a_max : i_blue;
        l_min   = (i_red < i_green) ? i_red : i_green;
        l_min   = (l_min < i_blue) ? l_min : i_blue;
        n_a_d   = n_a_max - l_min;
        // first matching sector wins on ties
        if (n_a_max == i_red && i_green >= i_blue) begin
            n_a_sec  = SEC_RED_POS;
            n_a_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n_a_max == i_red) begin
            n_a_sec  = SEC_RED_NEG;
            n_a_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n_a_max == i_green) begin
            n_a_sec  = SEC_GREEN;
            n_a_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a_sec  = SEC_BLUE;
            n_a_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_comb begin
        unique case (r_a_sec)
            SEC_RED_POS: l_k = HUE_K_RED_POS;
            SEC_RED_NEG: l_k = HUE_K_RED_NEG;
            SEC_GREEN:   l_k = HUE_K_GREEN;
            SEC_BLUE:    l_k = HUE_K_BLUE;
            default:     l_k = HUE_K_RED_POS;
        endcase
        l_base      = NUM_W'(l_k) * NUM_W'(r_a_d);
        l_diff_ext  = {{(SUM_W-PIX_W-1){r_a_diff[PIX_W]}}, r_a_diff};
        // never negative, never reaches 17*360*d
        l_sum       = $signed({1'b0, l_base}) + l_diff_ext * HUE_K_DIFF;
        n_b_hue_num = l_sum[NUM_W-1:0];
        n_b_hue_dvs = (DVS_W'(r_a_d) << 4) + (DVS_W'(r_a_d) << 3);
        n_b_sat_num = (NUM_W'(r_a_d) << 8) - NUM_W'(r_a_d);
        n_b_sat_dvs = DVS_W'(r_a_max);
        n_b_side.zero       = (r_a_d == '0);
        n_b_side.brightness = r_a_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
        r_a_max     <= n_a_max;
        r_a_d       <= n_a_d;
        r_a_sec     <= n_a_sec;
        r_a_diff    <= n_a_diff;
        r_b_hue_num <= n_b_hue_num;
        r_b_hue_dvs <= n_b_hue_dvs;
        r_b_sat_num <= n_b_sat_num;
        r_b_sat_dvs <= n_b_sat_dvs;
        r_b_side    <= n_b_side;
    end

    assign o_vld     = r_b_vld;
    assign o_hue_num = r_b_hue_num;
    assign o_hue_dvs = r_b_hue_dvs;
    assign o_sat_num = r_b_sat_num;
    assign o_sat_dvs = r_b_sat_dvs;
    assign o_side    = r_b_side;

endmodule

### hdl/hsvc_divide.sv
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module hsvc_divide
    import hsvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [NUM_W-1:0]     i_hue_num,
    input  logic [DVS_W-1:0]     i_hue_dvs,
    input  logic [NUM_W-1:0]     i_sat_num,
    input  logic [DVS_W-1:0]     i_sat_dvs,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [PIX_W-1:0]     o_hue_quo,
    output logic [PIX_W-1:0]     o_sat_quo,
    output t_side                o_side
);

    logic  r_vld  [DIV_STEPS];
    t_lane r_hue  [DIV_STEPS];
    t_lane r_sat  [DIV_STEPS];
    t_side r_side [DIV_STEPS];
    t_lane n_hue  [DIV_STEPS];
    t_lane n_sat  [DIV_STEPS];

    always_comb begin
        n_hue[0] = lane_step(lane_load(i_hue_num, i_hue_dvs));
        n_sat[0] = lane_step(lane_load(i_sat_num, i_sat_dvs));
        for (int j = 1; j < DIV_STEPS; j++) begin
            n_hue[j] = lane_step(r_hue[j-1]);
            n_sat[j] = lane_step(r_sat[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
        r_side[0] <= i_side;
        for (int j = 1; j < DIV_STEPS; j++) begin
            r_side[j] <= r_side[j-1];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_hue[j] <= n_hue[j];
            r_sat[j] <= n_sat[j];
        end
    end

    assign o_vld     = r_vld[DIV_STEPS-1];
    assign o_hue_quo = PIX_W'(r_hue[DIV_STEPS-1].quo);
    assign o_sat_quo = PIX_W'(r_sat[DIV_STEPS-1].quo);
    assign o_side    = r_side[DIV_STEPS-1];

endmodule

### hdl/rgb_to_hsv_pixel_converter.sv
// Top level of the RGB to HSV pixel converter.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  pixel in  i_red, i_green, i_blue (8 b each)        start high and busy low
//  hsv out   o_hue, o_saturation, o_brightness (8 b)  o_valid high for one cycle
//
//  One word enters per clock; busy never rises. Each word passes, after it is
//  taken, through two front stages (max/min and sector, then dividend and
//  divisor), eight divider stages that each yield one quotient bit, and the
//  output register. The eight-bit quotient sets the divider depth.
//  Synchronous reset clears all valid bits; data registers are not reset.
//  The receiver takes every result in its strobe cycle, so nothing stalls.
module rgb_to_hsv_pixel_converter
    import hsvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_hue,
    output logic [PIX_W-1:0] o_saturation,
    output logic [PIX_W-1:0] o_brightness
);

    logic             l_f_vld;
    logic [NUM_W-1:0] l_hue_num;
    logic [DVS_W-1:0] l_hue_dvs;
    logic [NUM_W-1:0] l_sat_num;
    logic [DVS_W-1:0] l_sat_dvs;
    t_side            l_f_side;

    logic             l_d_vld;
    logic [PIX_W-1:0] l_hue_quo;
    logic [PIX_W-1:0] l_sat_quo;
    t_side            l_d_side;

    logic             r_valid;
    logic [PIX_W-1:0] r_hue, n_hue;
    logic [PIX_W-1:0] r_sat, n_sat;
    logic [PIX_W-1:0] r_bright;

    // Pipeline always flows
    assign busy = 1'b0;

    hsvc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_vld     (l_f_vld),
        .o_hue_num (l_hue_num),
        .o_hue_dvs (l_hue_dvs),
        .o_sat_num (l_sat_num),
        .o_sat_dvs (l_sat_dvs),
        .o_side    (l_f_side)
    );

    hsvc_divide u_divide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (l_f_vld),
        .i_hue_num (l_hue_num),
        .i_hue_dvs (l_hue_dvs),
        .i_sat_num (l_sat_num),
        .i_sat_dvs (l_sat_dvs),
        .i_side    (l_f_side),
        .o_vld     (l_d_vld),
        .o_hue_quo (l_hue_quo),
        .o_sat_quo (l_sat_quo),
        .o_side    (l_d_side)
    );

    // Black and grey pixels: drop the quotients, the hue divisor was zero
    always_comb begin
        n_hue = l_d_side.zero ? '0 : l_hue_quo;
        n_sat = l_d_side.zero ? '0 : l_sat_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= l_d_vld;
        end
        r_hue    <= n_hue;
        r_sat    <= n_sat;
        r_bright <= l_d_side.brightness;
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

### sim/rgb_to_hsv_pixel_converter_tb.sv
// Self-checking testbench for the RGB to HSV pixel converter: predicted HSV words vs. DUT output.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_converter_tb;
    import hsvc_pkg::*;

    // Pipeline depth in registers from input to output; used only for the final drain pause
    localparam int LATENCY        = 11;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_PIXELS  = 750;
    localparam int MAX_GAP        = 7;

    localparam int FULL_SCALE = 255;
    localparam int DEG_FULL   = 360;
    localparam int DEG_SECTOR = 60;
    localparam int DEG_GREEN  = 120;
    localparam int DEG_BLUE   = 240;

    // One pixel waiting to be sent, with the idle cycles that come before it
    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        int unsigned      gap;
    } t_pixel_word;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] brightness;
    } t_hsv_word;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    logic [PIX_W-1:0] i_red   = '0;
    logic [PIX_W-1:0] i_green = '0;
    logic [PIX_W-1:0] i_blue  = '0;
    logic             o_valid;
    logic [PIX_W-1:0] o_hue;
    logic [PIX_W-1:0] o_saturation;
    logic [PIX_W-1:0] o_brightness;

    t_pixel_word pixel_q[$];        // pixels not yet presented to the block
    t_hsv_word   hsv_expected_q[$]; // predicted HSV words, oldest first
    int unsigned gap_count   = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;

    rgb_to_hsv_pixel_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Compute the HSV word of one pixel with exact integer floors.
    // The hue sector is picked by the first matching rule: red with green >= blue,
    // red with blue > green, green, then blue; ties fall to the earlier rule.
    function automatic t_hsv_word predict_hsv(input logic [PIX_W-1:0] r_in,
                                              input logic [PIX_W-1:0] g_in,
                                              input logic [PIX_W-1:0] b_in);
        int        r, g, b, top, bottom, span, degrees;
        t_sector   sector;
        t_hsv_word w;
        r = r_in;
        g = g_in;
        b = b_in;
        top    = (r > g) ? r : g;
        top    = (top > b) ? top : b;
        bottom = (r < g) ? r : g;
        bottom = (bottom < b) ? bottom : b;
        span   = top - bottom;
        w.hue        = '0;
        w.saturation = '0;
        w.brightness = PIX_W'(top);
        // Black and grey pixels carry no hue and no saturation
        if (top != 0 && span != 0) begin
            w.saturation = PIX_W'((FULL_SCALE * span) / top);
            if (top == r && g >= b)
                sector = SEC_RED_POS;
            else if (top == r)
                sector = SEC_RED_NEG;
            else if (top == g)
                sector = SEC_GREEN;
            else
                sector = SEC_BLUE;
            // degrees holds the hue angle times span, never negative
            case (sector)
                SEC_RED_POS: degrees = DEG_SECTOR * (g - b);
                SEC_RED_NEG: degrees = DEG_FULL * span - DEG_SECTOR * (b - g);
                SEC_GREEN:   degrees = DEG_GREEN * span + DEG_SECTOR * (b - r);
                default:     degrees = DEG_BLUE * span + DEG_SECTOR * (r - g);
            endcase
            w.hue = PIX_W'((degrees * FULL_SCALE) / (DEG_FULL * span));
        end
        return w;
    endfunction

    task automatic queue_pixel(input int r, input int g, input int b, input int unsigned gap);
        t_pixel_word p;
        p.red   = PIX_W'(r);
        p.green = PIX_W'(g);
        p.blue  = PIX_W'(b);
        p.gap   = gap;
        pixel_q.push_back(p);
    endtask

    // Keep a channel inside 0..255 after a small offset
    function automatic int clamp_channel(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Draw one random pixel; bias toward ties, near-grey and extreme channels,
    // since those pick the hue sector and the small-divisor corners.
    task automatic queue_random_pixel(input int unsigned gap);
        int base, r, g, b, mode, tie;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        case (mode)
            5: begin
                // near grey: every channel within a few steps of one level
                r = clamp_channel(base + $urandom_range(0, 4) - 2);
                g = clamp_channel(base + $urandom_range(0, 4) - 2);
                b = clamp_channel(base + $urandom_range(0, 4) - 2);
            end
            6: begin
                // two channels tied, either as the maximum or the minimum
                tie = $urandom_range(0, 2);
                if (tie == 0) g = r;
                else if (tie == 1) b = g;
                else b = r;
            end
            7: begin
                // one channel pinned at an extreme
                tie = $urandom_range(0, 2);
                base = $urandom_range(0, 1) ? 255 : 0;
                if (tie == 0) r = base;
                else if (tie == 1) g = base;
                else b = base;
            end
            8: begin
                r = base;
                g = base;
                b = base;
            end
            default: ;
        endcase
        queue_pixel(r, g, b, gap);
    endtask

    // Driver: present the head of the pixel queue once its gap has elapsed.
    // Hold the word while busy; advance to the next one on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                hsv_expected_q.push_back(predict_hsv(i_red, i_green, i_blue));
            if (!start || !busy) begin
                if (pixel_q.size() == 0) begin
                    start <= 1'b0;
                end else if (gap_count < pixel_q[0].gap) begin
                    gap_count <= gap_count + 1;
                    start     <= 1'b0;
                end else begin
                    start     <= 1'b1;
                    i_red     <= pixel_q[0].red;
                    i_green   <= pixel_q[0].green;
                    i_blue    <= pixel_q[0].blue;
                    gap_count <= 0;
                    pixel_q.pop_front();
                end
            end
        end
    end

    // Monitor: every strobed word must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (hsv_expected_q.size() == 0) begin
                $error("unexpected HSV word: hue %0d saturation %0d brightness %0d",
                       o_hue, o_saturation, o_brightness);
                fail_count++;
            end else begin
                if (o_hue !== hsv_expected_q[0].hue) begin
                    $error("hue mismatch: expected %0d, got %0d",
                           hsv_expected_q[0].hue, o_hue);
                    fail_count++;
                end
                if (o_saturation !== hsv_expected_q[0].saturation) begin
                    $error("saturation mismatch: expected %0d, got %0d",
                           hsv_expected_q[0].saturation, o_saturation);
                    fail_count++;
                end
                if (o_brightness !== hsv_expected_q[0].brightness) begin
                    $error("brightness mismatch: expected %0d, got %0d",
                           hsv_expected_q[0].brightness, o_brightness);
                    fail_count++;
                end
                hsv_expected_q.pop_front();
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("rgb_to_hsv_pixel_converter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned gap;

        // Directed pixels: black, white, greys, primaries, ties between maxima,
        // and the hue wrap just below 360 degrees. Send back to back first.
        queue_pixel(  0,   0,   0, 0);  // black
        queue_pixel(255, 255, 255, 0);  // white
        queue_pixel(128, 128, 128, 0);  // mid grey
        queue_pixel(  1,   1,   1, 0);
        queue_pixel(255,   0,   0, 0);  // pure red
        queue_pixel(  0, 255,   0, 0);  // pure green
        queue_pixel(  0,   0, 255, 0);  // pure blue
        queue_pixel(255, 255,   0, 0);  // red and green tied at the top
        queue_pixel(  0, 255, 255, 0);  // green and blue tied at the top
        queue_pixel(255,   0, 255, 1);  // red and blue tied: red sector, blue above green
        queue_pixel(255,   0,   1, 2);  // hue just short of a full turn
        queue_pixel(255,   1,   0, 3);
        queue_pixel(  1,   0,   0, 0);  // smallest nonzero span
        queue_pixel(  0,   1,   0, 0);
        queue_pixel(  0,   0,   1, 0);
        queue_pixel(255, 254, 254, 4);
        queue_pixel(254, 255, 255, 7);
        queue_pixel(170,  85, 170, 0);  // alternating bit patterns
        queue_pixel( 85, 170,  85, 0);
        queue_pixel(  0, 255, 128, 5);
        queue_pixel(128,   0, 255, 6);
        queue_pixel(255, 128,   0, 0);

        // Random pixels in stretches of 50: every other stretch runs back to back
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            gap = ((i / 50) % 2 == 0) ? $urandom_range(0, MAX_GAP) : 0;
            queue_random_pixel(gap);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait until every pixel is taken and every HSV word has come back
        do
            @(negedge i_clk);
        while (pixel_q.size() != 0 || start || hsv_expected_q.size() != 0);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (hsv_expected_q.size() != 0) begin
            $error("%0d HSV words never arrived", hsv_expected_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("rgb_to_hsv_pixel_converter verification clean");
        else
            $display("rgb_to_hsv_pixel_converter verification failed");
        $finish;
    end

endmodule
